[design/llrs_pkg.sv]
// ----------------------------------------------------------------------------
// llrs_pkg
// Types and constants shared by the Life-like automaton row step unit.
// ----------------------------------------------------------------------------
package llrs_pkg;

  localparam int unsigned COLS_DEFAULT = 64;
  localparam int unsigned ROW_W        = 64;
  localparam int unsigned GEN_W        = 32;
  localparam int unsigned MASK_W       = 9;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 1'b1;

  localparam logic [MASK_W-1:0] BIRTH_MASK_RESET   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_MASK_RESET = 9'd12;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row_cells;
    logic             end_of_generation;
    logic [GEN_W-1:0] generation_number;
  } out_t;

endpackage

[design/life_like_automaton_row_step_unit.sv]
// ----------------------------------------------------------------------------
// life_like_automaton_row_step_unit
// Streams one generation of a Life-like automaton row by row, B/S masks.
// ----------------------------------------------------------------------------
// Each result beat is registered in the result queue when its row is accepted.
// Throughput: one row per cycle while in_stall is low; a last row yields two
// beats when a row is buffered, and the input stalls while the three-entry
// result queue holds two or more beats. Reset clears the row buffers, the
// generation count and the result queue, and loads the masks with B3 / S23.
module life_like_automaton_row_step_unit #(
  parameter int unsigned COLS = llrs_pkg::COLS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  llrs_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output llrs_pkg::out_t                 out_data,
  input  logic                           cfg_write,
  input  logic [llrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llrs_pkg::MASK_W-1:0]    cfg_data
);

  localparam int unsigned ROW_W = llrs_pkg::ROW_W;
  localparam int unsigned MW    = llrs_pkg::MASK_W;
  localparam int unsigned GEN_W = llrs_pkg::GEN_W;
  localparam logic [ROW_W-1:0] COL_MASK =
    (COLS >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << COLS) - ROW_W'(1));

  logic [MW-1:0]              birth_mask;
  logic [MW-1:0]              survive_mask;
  logic [ROW_W-1:0]           row_above;
  logic [ROW_W-1:0]           row_middle;
  logic [1:0]                 rows_buffered;
  logic [llrs_pkg::GEN_W-1:0] generation_count;

  llrs_pkg::out_t queue [3];
  logic [1:0]     rd_ptr;
  logic [1:0]     wr_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;

  logic             accept;
  logic             pop;
  logic             have_row;
  logic [ROW_W-1:0] incoming;
  logic [ROW_W-1:0] first_cells;
  logic [ROW_W-1:0] second_cells;
  llrs_pkg::out_t   first_beat;
  llrs_pkg::out_t   second_beat;
  logic [1:0]       push_n;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  function automatic logic [ROW_W-1:0] next_row(
    input logic [ROW_W-1:0] up,
    input logic [ROW_W-1:0] mid,
    input logic [ROW_W-1:0] down,
    input logic [MW-1:0]    bmask,
    input logic [MW-1:0]    smask
  );
    logic [ROW_W+1:0] pu;
    logic [ROW_W+1:0] pm;
    logic [ROW_W+1:0] pd;
    logic [3:0]       n;
    logic [ROW_W-1:0] res;
    pu  = {1'b0, up, 1'b0};
    pm  = {1'b0, mid, 1'b0};
    pd  = {1'b0, down, 1'b0};
    res = '0;
    for (int i = 0; i < ROW_W; i++) begin
      n = 4'(pu[i]) + 4'(pu[i+1]) + 4'(pu[i+2])
        + 4'(pm[i]) + 4'(pm[i+2])
        + 4'(pd[i]) + 4'(pd[i+1]) + 4'(pd[i+2]);
      res[i] = mid[i] ? smask[n] : bmask[n];
    end
    return res & COL_MASK;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = (count > 2'd1);
  assign have_row = (rows_buffered != 2'd0);
  assign incoming = in_data.row_cells & COL_MASK;

  assign first_cells  = next_row(row_above, row_middle, incoming, birth_mask, survive_mask);
  assign second_cells = next_row(row_middle, incoming, '0, birth_mask, survive_mask);

  always_comb begin
    first_beat.next_row_cells     = first_cells;
    first_beat.end_of_generation  = 1'b0;
    first_beat.generation_number  = generation_count + GEN_W'(1);
    second_beat.next_row_cells    = second_cells;
    second_beat.end_of_generation = 1'b1;
    second_beat.generation_number = generation_count + GEN_W'(1);
  end

  always_comb begin
    push_n = 2'd0;
    if (accept) begin
      push_n = 2'(have_row) + 2'(in_data.last_row);
    end
    count_next = count + push_n - 2'(pop);
  end

  assign out_valid = (count != 2'd0);
  assign out_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= llrs_pkg::BIRTH_MASK_RESET;
      survive_mask <= llrs_pkg::SURVIVE_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        llrs_pkg::REG_BIRTH_MASK:   birth_mask   <= cfg_data;
        llrs_pkg::REG_SURVIVE_MASK: survive_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above        <= '0;
      row_middle       <= '0;
      rows_buffered    <= 2'd0;
      generation_count <= '0;
    end else if (accept) begin
      if (in_data.last_row) begin
        row_above        <= '0;
        row_middle       <= '0;
        rows_buffered    <= 2'd0;
        generation_count <= generation_count + GEN_W'(1);
      end else begin
        row_above     <= row_middle;
        row_middle    <= incoming;
        rows_buffered <= have_row ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (have_row) begin
        queue[wr_ptr] <= first_beat;
        if (in_data.last_row) begin
          queue[ptr_inc(wr_ptr)] <= second_beat;
        end
      end else if (in_data.last_row) begin
        queue[wr_ptr] <= second_beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case (push_n)
        2'd1:    wr_ptr <= ptr_inc(wr_ptr);
        2'd2:    wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd3)
    else $error("result queue overflow");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_row |=>
      rows_buffered == 2'd0 && generation_count == $past(generation_count) + GEN_W'(1))
    else $error("last row did not close the generation");

  a_row_shift: assert property (@(posedge clk) disable iff (rst)
    accept && !in_data.last_row && have_row |=> rows_buffered == 2'd2)
    else $error("row buffers did not advance");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    rd_ptr != 2'd3 && wr_ptr != 2'd3)
    else $error("queue pointer out of range");

endmodule
